// ===== src/peu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package peu_pkg;

  localparam int FRAC_BITS = 16;

  localparam int FUNC_W = 4;
  localparam int POS_W  = FRAC_BITS + 1;
  localparam int TD_W   = ((POS_W + 7) / 8) * 8;
  localparam int M_W    = FRAC_BITS + 2;
  localparam int P2_W   = 2 * FRAC_BITS + 1;
  localparam int P4_W   = 4 * FRAC_BITS + 1;
  localparam int LO_W   = 2 * FRAC_BITS;
  localparam int HI_W   = P4_W - LO_W;
  localparam int PPL_W  = LO_W + POS_W;
  localparam int PPH_W  = HI_W + POS_W;
  localparam int NUM_W  = 5 * FRAC_BITS + 1;
  localparam int RND_W  = NUM_W + 1;
  localparam int SH_W   = $clog2(4 * FRAC_BITS + 1);

  localparam logic [POS_W-1:0] ONE  = POS_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0] HALF = ONE >> 1;

  localparam logic [FUNC_W-1:0] FN_LINEAR      = 4'd0;
  localparam logic [FUNC_W-1:0] FN_SMOOTH      = 4'd1;
  localparam logic [FUNC_W-1:0] FN_QUAD_IN     = 4'd2;
  localparam logic [FUNC_W-1:0] FN_QUAD_OUT    = 4'd3;
  localparam logic [FUNC_W-1:0] FN_QUAD_INOUT  = 4'd4;
  localparam logic [FUNC_W-1:0] FN_CUBIC_IN    = 4'd5;
  localparam logic [FUNC_W-1:0] FN_CUBIC_OUT   = 4'd6;
  localparam logic [FUNC_W-1:0] FN_CUBIC_INOUT = 4'd7;
  localparam logic [FUNC_W-1:0] FN_QUART_IN    = 4'd8;
  localparam logic [FUNC_W-1:0] FN_QUART_OUT   = 4'd9;
  localparam logic [FUNC_W-1:0] FN_QUART_INOUT = 4'd10;
  localparam logic [FUNC_W-1:0] FN_QUINT_IN    = 4'd11;
  localparam logic [FUNC_W-1:0] FN_QUINT_OUT   = 4'd12;
  localparam logic [FUNC_W-1:0] FN_QUINT_INOUT = 4'd13;

  typedef enum logic [1:0] {
    MODE_ZERO = 2'd0,
    MODE_LIN  = 2'd1,
    MODE_POW  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    OP_ONE    = 2'd0,
    OP_V      = 2'd1,
    OP_SQ     = 2'd2,
    OP_SMOOTH = 2'd3
  } opsel_t;

  typedef struct packed {
    mode_t             mode;
    logic              upper;
    logic              pow5;
    opsel_t            opsel;
    logic [SH_W-1:0]   shift;
    logic [POS_W-1:0]  x;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== src/peu_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module peu_decode (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          up_vld,
  output logic                         up_rdy,
  input  wire  [peu_pkg::FUNC_W-1:0]   up_func,
  input  wire  [peu_pkg::POS_W-1:0]    up_pos,
  output logic                         dn_vld,
  input  wire                          dn_rdy,
  output peu_pkg::ctrl_t               dn_ctrl,
  output logic [peu_pkg::POS_W-1:0]    dn_v,
  output logic [peu_pkg::M_W-1:0]      dn_m
);
  import peu_pkg::*;

  logic              vld_r;
  ctrl_t             ctrl_r, ctrl_nxt;
  logic [POS_W-1:0]  v_r, v_nxt;
  logic [M_W-1:0]    m_r, m_nxt;
  logic [POS_W-1:0]  x_sat, y;
  logic [2:0]        nm1;
  logic              pow_f, inout_f;
  logic              en;

  assign en     = !vld_r || dn_rdy;
  assign up_rdy = en;

  always_comb begin
    x_sat   = (up_pos > ONE) ? ONE : up_pos;
    y       = ONE - x_sat;
    nm1     = 3'd0;
    pow_f   = 1'b0;
    inout_f = 1'b0;
    ctrl_nxt.mode  = MODE_ZERO;
    ctrl_nxt.upper = 1'b0;
    ctrl_nxt.pow5  = 1'b0;
    ctrl_nxt.opsel = OP_ONE;
    ctrl_nxt.shift = '0;
    ctrl_nxt.x     = x_sat;

    case (up_func)
      FN_LINEAR: begin
        ctrl_nxt.mode = MODE_LIN;
      end
      FN_SMOOTH: begin
        ctrl_nxt.mode  = MODE_POW;
        ctrl_nxt.opsel = OP_SMOOTH;
        ctrl_nxt.shift = SH_W'(2 * FRAC_BITS);
      end
      FN_QUAD_IN, FN_QUAD_OUT, FN_QUAD_INOUT: begin
        nm1   = 3'd1;
        pow_f = 1'b1;
      end
      FN_CUBIC_IN, FN_CUBIC_OUT, FN_CUBIC_INOUT: begin
        nm1   = 3'd2;
        pow_f = 1'b1;
      end
      FN_QUART_IN, FN_QUART_OUT, FN_QUART_INOUT: begin
        nm1   = 3'd3;
        pow_f = 1'b1;
      end
      FN_QUINT_IN, FN_QUINT_OUT, FN_QUINT_INOUT: begin
        nm1   = 3'd4;
        pow_f = 1'b1;
      end
      default: begin
        ctrl_nxt.mode = MODE_ZERO;
      end
    endcase

    case (up_func)
      FN_QUAD_OUT, FN_CUBIC_OUT, FN_QUART_OUT, FN_QUINT_OUT: begin
        ctrl_nxt.upper = 1'b1;
      end
      FN_QUAD_INOUT, FN_CUBIC_INOUT, FN_QUART_INOUT, FN_QUINT_INOUT: begin
        inout_f        = 1'b1;
        ctrl_nxt.upper = (x_sat >= HALF);
      end
      default: begin
        inout_f = 1'b0;
      end
    endcase

    if (pow_f) begin
      ctrl_nxt.mode = MODE_POW;
      ctrl_nxt.pow5 = (nm1 == 3'd4);
      case (nm1)
        3'd1:    ctrl_nxt.opsel = OP_ONE;
        3'd2:    ctrl_nxt.opsel = OP_V;
        default: ctrl_nxt.opsel = OP_SQ;
      endcase
      if (inout_f) begin
        ctrl_nxt.shift = SH_W'(nm1) * SH_W'(FRAC_BITS - 1);
      end else begin
        ctrl_nxt.shift = SH_W'(nm1) * SH_W'(FRAC_BITS);
      end
    end

    v_nxt = ctrl_nxt.upper ? y : x_sat;
    m_nxt = M_W'(3 * (1 << FRAC_BITS)) - {x_sat, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_vld) begin
      ctrl_r <= ctrl_nxt;
      v_r    <= v_nxt;
      m_r    <= m_nxt;
    end
  end

  assign dn_vld  = vld_r;
  assign dn_ctrl = ctrl_r;
  assign dn_v    = v_r;
  assign dn_m    = m_r;

endmodule

`default_nettype wire

// ===== src/peu_mult.sv =====
`timescale 1ns / 1ps
`default_nettype none

module peu_mult (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          up_vld,
  output logic                         up_rdy,
  input  peu_pkg::ctrl_t               up_ctrl,
  input  wire  [peu_pkg::POS_W-1:0]    up_v,
  input  wire  [peu_pkg::M_W-1:0]      up_m,
  output logic                         dn_vld,
  input  wire                          dn_rdy,
  output peu_pkg::ctrl_t               dn_ctrl,
  output logic [peu_pkg::PPL_W-1:0]    dn_lo,
  output logic [peu_pkg::PPH_W-1:0]    dn_hi
);
  import peu_pkg::*;

  // square stage
  logic              vld1_r;
  ctrl_t             ctrl1_r;
  logic [POS_W-1:0]  v1_r;
  logic [M_W-1:0]    m1_r;
  logic [P2_W-1:0]   sq1_r;
  logic [2*POS_W-1:0] sq_full;
  logic              en1;

  // general product stage
  logic              vld2_r;
  ctrl_t             ctrl2_r;
  logic [POS_W-1:0]  v2_r;
  logic [P4_W-1:0]   p2_r;
  logic [P2_W-1:0]   opb;
  logic [2*P2_W-1:0] prod_full;
  logic              en2;

  // split fifth power stage
  logic              vld3_r;
  ctrl_t             ctrl3_r;
  logic [PPL_W-1:0]  lo3_r;
  logic [PPH_W-1:0]  hi3_r;
  logic [POS_W-1:0]  mul3;
  logic [PPL_W-1:0]  lo_full;
  logic [PPH_W-1:0]  hi_full;
  logic              en3;

  assign en3    = !vld3_r || dn_rdy;
  assign en2    = !vld2_r || en3;
  assign en1    = !vld1_r || en2;
  assign up_rdy = en1;

  always_comb begin
    sq_full = up_v * up_v;
    case (ctrl1_r.opsel)
      OP_ONE:    opb = P2_W'(1);
      OP_V:      opb = P2_W'(v1_r);
      OP_SQ:     opb = sq1_r;
      OP_SMOOTH: opb = P2_W'(m1_r);
      default:   opb = P2_W'(1);
    endcase
    prod_full = sq1_r * opb;
    mul3      = ctrl2_r.pow5 ? v2_r : POS_W'(1);
    lo_full   = p2_r[LO_W-1:0] * mul3;
    hi_full   = p2_r[P4_W-1:LO_W] * mul3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      if (en1) begin
        vld1_r <= up_vld;
      end
      if (en2) begin
        vld2_r <= vld1_r;
      end
      if (en3) begin
        vld3_r <= vld2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && up_vld) begin
      ctrl1_r <= up_ctrl;
      v1_r    <= up_v;
      m1_r    <= up_m;
      sq1_r   <= sq_full[P2_W-1:0];
    end
    if (en2 && vld1_r) begin
      ctrl2_r <= ctrl1_r;
      v2_r    <= v1_r;
      p2_r    <= prod_full[P4_W-1:0];
    end
    if (en3 && vld2_r) begin
      ctrl3_r <= ctrl2_r;
      lo3_r   <= lo_full;
      hi3_r   <= hi_full;
    end
  end

  assign dn_vld  = vld3_r;
  assign dn_ctrl = ctrl3_r;
  assign dn_lo   = lo3_r;
  assign dn_hi   = hi3_r;

endmodule

`default_nettype wire

// ===== src/peu_round.sv =====
`timescale 1ns / 1ps
`default_nettype none

module peu_round (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          up_vld,
  output logic                         up_rdy,
  input  peu_pkg::ctrl_t               up_ctrl,
  input  wire  [peu_pkg::PPL_W-1:0]    up_lo,
  input  wire  [peu_pkg::PPH_W-1:0]    up_hi,
  output logic                         dn_vld,
  input  wire                          dn_rdy,
  output logic [peu_pkg::POS_W-1:0]    dn_eased
);
  import peu_pkg::*;

  // numerator sum
  logic              vld4_r;
  ctrl_t             ctrl4_r;
  logic [NUM_W-1:0]  num4_r, num_nxt;
  logic              en4;

  // rounding
  logic              vld5_r;
  ctrl_t             ctrl5_r;
  logic [POS_W-1:0]  q5_r, q_nxt;
  logic [RND_W-1:0]  rnd, sum, qw;
  logic              en5;

  // result register
  logic              vld6_r;
  logic [POS_W-1:0]  eased6_r, eased_nxt;
  logic              en6;

  assign en6    = !vld6_r || dn_rdy;
  assign en5    = !vld5_r || en6;
  assign en4    = !vld4_r || en5;
  assign up_rdy = en4;

  always_comb begin
    num_nxt = (NUM_W'(up_hi) << LO_W) + NUM_W'(up_lo);

    // half down for the upper branch so that one minus the value rounds half up
    rnd   = (RND_W'(1) << (ctrl4_r.shift - SH_W'(1))) - RND_W'(ctrl4_r.upper);
    sum   = {1'b0, num4_r} + rnd;
    qw    = sum >> ctrl4_r.shift;
    q_nxt = (qw > RND_W'(ONE)) ? ONE : qw[POS_W-1:0];

    case (ctrl5_r.mode)
      MODE_LIN:  eased_nxt = ctrl5_r.x;
      MODE_POW:  eased_nxt = ctrl5_r.upper ? (ONE - q5_r) : q5_r;
      default:   eased_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else begin
      if (en4) begin
        vld4_r <= up_vld;
      end
      if (en5) begin
        vld5_r <= vld4_r;
      end
      if (en6) begin
        vld6_r <= vld5_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && up_vld) begin
      ctrl4_r <= up_ctrl;
      num4_r  <= num_nxt;
    end
    if (en5 && vld4_r) begin
      ctrl5_r <= ctrl4_r;
      q5_r    <= q_nxt;
    end
    if (en6 && vld5_r) begin
      eased6_r <= eased_nxt;
    end
  end

  assign dn_vld   = vld6_r;
  assign dn_eased = eased6_r;

endmodule

`default_nettype wire

// ===== src/polynomial_easing_unit.sv =====
// channel  | dir | ports                               | contents
// in       | in  | in_tvalid, in_tready, in_tdata/user | position, function code
// out      | out | out_tvalid, out_tready, out_tdata   | eased value
//
// one transaction per cycle in and out while out_tready stays high
// seven register stages: decode, square, product, fifth power split, sum, round, output
// rst_n is synchronous and clears the valid bits of all stages
// a stalled output fills the empty stages first; in_tready drops only when all are full
`timescale 1ns / 1ps
`default_nettype none

module polynomial_easing_unit (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [peu_pkg::TD_W-1:0]     in_tdata,  // position
  input  wire  [peu_pkg::FUNC_W-1:0]   in_tuser,  // func
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [peu_pkg::TD_W-1:0]     out_tdata  // eased
);
  import peu_pkg::*;

  logic              dec_vld, dec_rdy;
  ctrl_t             dec_ctrl;
  logic [POS_W-1:0]  dec_v;
  logic [M_W-1:0]    dec_m;

  logic              mul_vld, mul_rdy;
  ctrl_t             mul_ctrl;
  logic [PPL_W-1:0]  mul_lo;
  logic [PPH_W-1:0]  mul_hi;

  logic [POS_W-1:0]  eased;

  peu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (in_tvalid),
    .up_rdy  (in_tready),
    .up_func (in_tuser),
    .up_pos  (in_tdata[POS_W-1:0]),
    .dn_vld  (dec_vld),
    .dn_rdy  (dec_rdy),
    .dn_ctrl (dec_ctrl),
    .dn_v    (dec_v),
    .dn_m    (dec_m)
  );

  peu_mult u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (dec_vld),
    .up_rdy  (dec_rdy),
    .up_ctrl (dec_ctrl),
    .up_v    (dec_v),
    .up_m    (dec_m),
    .dn_vld  (mul_vld),
    .dn_rdy  (mul_rdy),
    .dn_ctrl (mul_ctrl),
    .dn_lo   (mul_lo),
    .dn_hi   (mul_hi)
  );

  peu_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_vld   (mul_vld),
    .up_rdy   (mul_rdy),
    .up_ctrl  (mul_ctrl),
    .up_lo    (mul_lo),
    .up_hi    (mul_hi),
    .dn_vld   (out_tvalid),
    .dn_rdy   (out_tready),
    .dn_eased (eased)
  );

  assign out_tdata = TD_W'(eased);

endmodule

`default_nettype wire

// ===== src/peu_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module peu_checker (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tready,
  input  wire                          out_tvalid,
  input  wire                          out_tready,
  input  wire  [peu_pkg::TD_W-1:0]     out_tdata
);
  import peu_pkg::*;

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // eased value stays within zero to one, padding clear
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata <= TD_W'(ONE)))
    else $error("eased value above one");

  // a stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled output changed");

  // the pipeline never blocks the input while the output drains
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input blocked while output free");

endmodule

bind polynomial_easing_unit peu_checker u_peu_checker (.*);

`default_nettype wire

// ===== test/tb_polynomial_easing_unit.sv =====
`timescale 1ns / 1ps

module tb_polynomial_easing_unit;
  import peu_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = 20;

  // codes past the quintic group, both decode to zero
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = FN_QUINT_INOUT + 4'd1;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = FN_QUINT_INOUT + 4'd2;

  typedef enum int {
    EASE_IN    = 0,
    EASE_OUT   = 1,
    EASE_INOUT = 2
  } ease_shape_t;

  typedef struct {
    logic [FUNC_W-1:0] fn;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  eased;
  } eased_entry_t;

  class ease_scoreboard;
    eased_entry_t expected_eased[$];
    int           errors;

    function new();
      errors = 0;
    endfunction

    // value / 2^s rounded half up, or half down for the upper branch
    function logic [127:0] round_shift(logic [127:0] value, int s, bit half_down);
      logic [127:0] v;
      v = value;
      if (half_down && v != 0) v = v - 128'(1);
      v = v + (128'(1) << (s - 1));
      return v >> s;
    endfunction

    function logic [POS_W-1:0] ease_value(logic [FUNC_W-1:0] fn, logic [POS_W-1:0] pos);
      logic [127:0] x, y, base, num, q;
      int           n, sh;
      bit           upper;
      ease_shape_t  shape;
      x = (pos > ONE) ? 128'(ONE) : 128'(pos);
      y = 128'(ONE) - x;
      if (fn == FN_LINEAR) return POS_W'(x);
      if (fn == FN_SMOOTH) begin
        num = x * x * (128'(3) * 128'(ONE) - 128'(2) * x);
        q = round_shift(num, 2 * FRAC_BITS, 1'b0);
        return (q > ONE) ? ONE : POS_W'(q);
      end
      if (fn > FN_QUINT_INOUT) return '0;
      n = (int'(fn) - int'(FN_QUAD_IN)) / 3 + 2;
      shape = ease_shape_t'((int'(fn) - int'(FN_QUAD_IN)) % 3);
      case (shape)
        EASE_IN: begin
          base = x;
          sh = (n - 1) * FRAC_BITS;
          upper = 1'b0;
        end
        EASE_OUT: begin
          base = y;
          sh = (n - 1) * FRAC_BITS;
          upper = 1'b1;
        end
        default: begin
          upper = (x >= HALF);
          base = upper ? y : x;
          sh = (n - 1) * (FRAC_BITS - 1);
        end
      endcase
      num = 128'(1);
      repeat (n) num = num * base;
      q = round_shift(num, sh, upper);
      if (!upper) return (q > ONE) ? ONE : POS_W'(q);
      return (q > ONE) ? '0 : POS_W'(128'(ONE) - q);
    endfunction

    function void note_position(logic [FUNC_W-1:0] fn, logic [POS_W-1:0] pos);
      eased_entry_t e;
      e.fn = fn;
      e.pos = pos;
      e.eased = ease_value(fn, pos);
      expected_eased.push_back(e);
    endfunction

    function void check_eased(logic [TD_W-1:0] tdata);
      eased_entry_t e;
      if (expected_eased.size() == 0) begin
        $display("%0t: unexpected eased value, expected none, actual 0x%0h", $time, tdata);
        errors++;
        return;
      end
      e = expected_eased.pop_front();
      if (tdata !== TD_W'(e.eased)) begin
        $display("%0t: eased mismatch func %0d position 0x%0h: expected 0x%0h actual 0x%0h",
                 $time, e.fn, e.pos, TD_W'(e.eased), tdata);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [TD_W-1:0]   in_tdata;
  logic [FUNC_W-1:0] in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [TD_W-1:0]   out_tdata;

  ease_scoreboard sb = new();

  bit tx_random;
  bit rx_random;
  bit hold_request;
  int cycle_count = 0;

  polynomial_easing_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_position(in_tuser, in_tdata[POS_W-1:0]);
    if (rst_n && out_tvalid && out_tready) sb.check_eased(out_tdata);
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(99);
    if (r < 65) return POS_W'($urandom_range(0, ONE));
    if (r < 75) begin
      case ($urandom_range(2))
        0: return '0;
        1: return ONE;
        default: return HALF;
      endcase
    end
    if (r < 80) return POS_W'(HALF + $urandom_range(0, 2) - 1);
    return POS_W'($urandom);
  endfunction

  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos);
    int gap;
    gap = tx_random ? idle_length() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= TD_W'(pos);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_item(FUNC_W'($urandom_range(15)), pick_position());
  endtask

  task automatic wait_drained();
    while (sb.expected_eased.size() != 0) @(posedge clk);
  endtask

  // receiver
  initial begin
    int len;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        len = rx_random ? idle_length() : 0;
        if (len > 0) begin
          out_tready <= 1'b0;
          repeat (len) @(posedge clk);
        end else begin
          out_tready <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    logic [POS_W-1:0] edges [6];
    int               i;
    edges[0] = '0;
    edges[1] = ONE;
    edges[2] = HALF;
    edges[3] = '1;
    edges[4] = POS_W'(HALF - 1);
    edges[5] = POS_W'(1);
    tx_random = 1'b0;
    rx_random = 1'b0;
    hold_request = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every code once, each at one of the edge positions
    for (i = int'(FN_LINEAR); i <= int'(FN_SPARE_HI); i++)
      send_item(FUNC_W'(i), edges[i % 6]);
    // half boundary of inout, saturation and end points
    send_item(FN_QUAD_INOUT, HALF);
    send_item(FN_CUBIC_INOUT, POS_W'(HALF - 1));
    send_item(FN_QUART_INOUT, HALF);
    send_item(FN_QUINT_INOUT, POS_W'(HALF + 1));
    send_item(FN_QUINT_IN, ONE);
    send_item(FN_QUINT_OUT, '0);
    send_item(FN_SMOOTH, HALF);
    send_item(FN_QUART_OUT, POS_W'(ONE + 1));
    send_item(FN_SPARE_LO, '1);

    tx_random = 1'b1;
    rx_random = 1'b1;
    send_random(150);

    // back pressure until the pipeline is full
    tx_random = 1'b0;
    rx_random = 1'b0;
    hold_request = 1'b1;
    send_random(40);
    in_tvalid <= 1'b0;
    wait_drained();

    rx_random = 1'b1;
    send_random(100);

    tx_random = 1'b1;
    send_random(150);

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_eased.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
